// ----- design/touch_bitmap_finger_locator_macros.svh -----
// Assertion macros shared by the finger locator RTL.
`ifndef TOUCH_BITMAP_FINGER_LOCATOR_MACROS_SVH
`define TOUCH_BITMAP_FINGER_LOCATOR_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define TBFL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define TBFL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tbfl_pkg.sv -----
// Shared types, constants and helper functions for the finger locator.
`default_nettype none
package tbfl_pkg;

	localparam int MAP_BITS  = 32;
	localparam int POS_W     = $clog2(MAP_BITS);
	localparam int LEN_W     = POS_W + 1;
	localparam int CNT_W     = 5;
	localparam int RANGE_W   = 12;
	localparam int NUM_W     = POS_W + 1;
	localparam int PROD_W    = RANGE_W + NUM_W;
	localparam int DIVR_W    = POS_W + 1;
	localparam int DIV_STEPS = PROD_W / 2;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int COORD_W   = 17;
	localparam int IDX_W     = 2;

	localparam logic [IDX_W-1:0] REG_X_RANGE = 2'd0;
	localparam logic [IDX_W-1:0] REG_Y_RANGE = 2'd1;
	localparam logic [IDX_W-1:0] REG_X_LINES = 2'd2;
	localparam logic [IDX_W-1:0] REG_Y_LINES = 2'd3;

	localparam logic [RANGE_W-1:0] X_RANGE_RST = 12'd1360;
	localparam logic [RANGE_W-1:0] Y_RANGE_RST = 12'd660;
	localparam logic [LEN_W-1:0]   X_LINES_RST = 6'd23;
	localparam logic [LEN_W-1:0]   Y_LINES_RST = 6'd12;

	localparam logic [PROD_W-1:0]  POS_MAX = PROD_W'((1 << COORD_W) - 1);

	typedef struct packed {
		logic [POS_W-1:0] start;
		logic [LEN_W-1:0] len;
	} run_t;

	typedef struct packed {
		logic             prev;
		logic [CNT_W-1:0] cnt;
		run_t             lo;
		run_t             hi;
	} axis_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic split;
		logic mul;
		logic div;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic div_last;
		logic op_last;
	} sts_t;

	function automatic logic [LEN_W-1:0] clamp_lines(input logic [LEN_W-1:0] c);
		if (c < LEN_W'(2))
			return LEN_W'(2);
		if (c > LEN_W'(MAP_BITS))
			return LEN_W'(MAP_BITS);
		return c;
	endfunction

	// One scan position: open a new run or extend the current one.
	function automatic axis_t scan_bit(input axis_t a, input logic b,
		input logic [POS_W-1:0] pos);
		axis_t r;
		r = a;
		if (b) begin
			if (!a.prev) begin
				if (a.cnt != '0) begin
					r.hi.start = pos;
					r.hi.len   = LEN_W'(1);
				end else begin
					r.lo.start = pos;
					r.lo.len   = LEN_W'(1);
				end
				r.cnt = a.cnt + CNT_W'(1);
			end else if (a.cnt > CNT_W'(1)) begin
				r.hi.len = a.hi.len + LEN_W'(1);
			end else begin
				r.lo.len = a.lo.len + LEN_W'(1);
			end
		end
		r.prev = b;
		return r;
	endfunction

	// Split a lone run into two halves.
	function automatic axis_t split_axis(input axis_t a);
		axis_t            r;
		logic [LEN_W-1:0] half;
		r = a;
		half = a.lo.len >> 1;
		r.lo.len   = a.lo.len - half;
		r.hi.start = a.lo.start + half[POS_W-1:0];
		r.hi.len   = (half != '0) ? half : LEN_W'(1);
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- design/tbfl_ctrl.sv -----
// Controller state machine for the finger locator.
`default_nettype none
module tbfl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire tbfl_pkg::sts_t sts,
	output tbfl_pkg::cmd_t     cmd
);
	import tbfl_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_SPLIT = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last)
					state_d = ST_SPLIT;
			end
			ST_SPLIT: begin
				cmd.split = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_last)
					state_d = sts.op_last ? ST_OUT : ST_MUL;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- design/tbfl_dpath.sv -----
// Datapath: config registers, run scanner, scaler with shared divider, output word.
`default_nettype none
module tbfl_dpath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tbfl_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [tbfl_pkg::RANGE_W-1:0]    cfg_data,
	input  wire logic [tbfl_pkg::MAP_BITS-1:0]   x_map,
	input  wire logic [tbfl_pkg::MAP_BITS-1:0]   y_map,
	input  wire tbfl_pkg::cmd_t                  cmd,
	output tbfl_pkg::sts_t                       sts,
	output logic [tbfl_pkg::CNT_W-1:0]           finger_count,
	output logic [tbfl_pkg::COORD_W-1:0]         first_x,
	output logic [tbfl_pkg::COORD_W-1:0]         first_y,
	output logic [tbfl_pkg::COORD_W-1:0]         second_x,
	output logic [tbfl_pkg::COORD_W-1:0]         second_y
);
	import tbfl_pkg::*;

	logic [RANGE_W-1:0]  x_range_q, y_range_q;
	logic [LEN_W-1:0]    x_lines_q, y_lines_q;
	logic [LEN_W-1:0]    xl, yl;
	logic [MAP_BITS-1:0] ymask, ym_in;

	logic [MAP_BITS-1:0] xm_q, ym_q;
	logic                empty_q;
	logic [POS_W-1:0]    bit_q;
	axis_t               xa_q, ya_q;
	logic [LEN_W-1:0]    ydiff;
	logic                ybit;
	logic [CNT_W-1:0]    fmax;
	logic                multi;

	logic [1:0]          op_q;
	logic [RANGE_W-1:0]  op_mx;
	run_t                op_run;
	logic [LEN_W-1:0]    op_lines, lm1;
	logic [NUM_W:0]      nsum;
	logic [NUM_W-1:0]    num;
	logic [PROD_W-1:0]   prod;

	logic [PROD_W-1:0]   dnum_q, quo_q, q_next;
	logic [DIVR_W-1:0]   rem_q, dvsr_q;
	logic [STEP_W-1:0]   step_q;
	logic [DIVR_W:0]     r1, r1s, r2, r2s;
	logic                ge1, ge2;
	logic [COORD_W-1:0]  q_sat;
	logic [COORD_W-1:0]  res_q [4];

	logic [CNT_W-1:0]    finger_count_q;
	logic [COORD_W-1:0]  first_x_q, first_y_q, second_x_q, second_y_q;

	assign xl    = clamp_lines(x_lines_q);
	assign yl    = clamp_lines(y_lines_q);
	assign ymask = ~({MAP_BITS{1'b1}} << yl);
	assign ym_in = y_map & ymask;

	// Y is read top used line first
	assign ydiff = yl - LEN_W'(1) - LEN_W'(bit_q);
	assign ybit  = (LEN_W'(bit_q) < yl) ? ym_q[ydiff[POS_W-1:0]] : 1'b0;

	assign fmax  = (xa_q.cnt > ya_q.cnt) ? xa_q.cnt : ya_q.cnt;
	assign multi = (fmax > CNT_W'(1));

	always_comb begin
		case (op_q)
			2'd0: begin op_mx = x_range_q; op_run = xa_q.lo; op_lines = xl; end
			2'd1: begin op_mx = y_range_q; op_run = ya_q.lo; op_lines = yl; end
			2'd2: begin op_mx = x_range_q; op_run = xa_q.hi; op_lines = xl; end
			default: begin op_mx = y_range_q; op_run = ya_q.hi; op_lines = yl; end
		endcase
	end

	assign nsum = (NUM_W+1)'({op_run.start, 1'b0}) + (NUM_W+1)'(op_run.len);
	assign num  = (nsum == '0) ? '0 : NUM_W'(nsum - (NUM_W+1)'(1));
	assign prod = PROD_W'(op_mx) * PROD_W'(num);
	assign lm1  = op_lines - LEN_W'(1);

	// radix-4 restoring divide step
	assign r1  = {rem_q, dnum_q[PROD_W-1]};
	assign ge1 = (r1 >= {1'b0, dvsr_q});
	assign r1s = ge1 ? (r1 - {1'b0, dvsr_q}) : r1;
	assign r2  = {r1s[DIVR_W-1:0], dnum_q[PROD_W-2]};
	assign ge2 = (r2 >= {1'b0, dvsr_q});
	assign r2s = ge2 ? (r2 - {1'b0, dvsr_q}) : r2;
	assign q_next = {quo_q[PROD_W-3:0], ge1, ge2};
	assign q_sat  = (q_next > POS_MAX) ? POS_MAX[COORD_W-1:0] : q_next[COORD_W-1:0];

	assign sts.scan_last = (bit_q == POS_W'(MAP_BITS - 1));
	assign sts.div_last  = (step_q == STEP_W'(DIV_STEPS - 1));
	assign sts.op_last   = (op_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_range_q <= X_RANGE_RST;
			y_range_q <= Y_RANGE_RST;
			x_lines_q <= X_LINES_RST;
			y_lines_q <= Y_LINES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_RANGE: x_range_q <= cfg_data;
				REG_Y_RANGE: y_range_q <= cfg_data;
				REG_X_LINES: x_lines_q <= cfg_data[LEN_W-1:0];
				REG_Y_LINES: y_lines_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			step_q <= '0;
			op_q   <= '0;
		end else begin
			if (cmd.start) begin
				bit_q <= '0;
				op_q  <= '0;
			end else if (cmd.scan) begin
				bit_q <= bit_q + POS_W'(1);
			end
			if (cmd.mul)
				step_q <= '0;
			else if (cmd.div) begin
				step_q <= step_q + STEP_W'(1);
				if (sts.div_last)
					op_q <= op_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			xm_q    <= x_map;
			ym_q    <= ym_in;
			empty_q <= (x_map == '0) || (ym_in == '0);
			xa_q    <= '0;
			ya_q    <= '0;
		end else if (cmd.scan) begin
			xa_q <= scan_bit(xa_q, xm_q[bit_q], bit_q);
			ya_q <= scan_bit(ya_q, ybit, bit_q);
		end else if (cmd.split && multi) begin
			if (xa_q.cnt == CNT_W'(1))
				xa_q <= split_axis(xa_q);
			else if (ya_q.cnt == CNT_W'(1))
				ya_q <= split_axis(ya_q);
		end
		if (cmd.mul) begin
			dnum_q <= prod;
			quo_q  <= '0;
			rem_q  <= '0;
			dvsr_q <= {lm1[POS_W-1:0], 1'b0};
		end else if (cmd.div) begin
			dnum_q <= dnum_q << 2;
			quo_q  <= q_next;
			rem_q  <= r2s[DIVR_W-1:0];
			if (sts.div_last)
				res_q[op_q] <= q_sat;
		end
		if (cmd.load_out) begin
			finger_count_q <= empty_q ? '0 : fmax;
			first_x_q      <= empty_q ? '0 : res_q[0];
			first_y_q      <= empty_q ? '0 : res_q[1];
			second_x_q     <= (empty_q || !multi) ? '0 : res_q[2];
			second_y_q     <= (empty_q || !multi) ? '0 : res_q[3];
		end
	end

	assign finger_count = finger_count_q;
	assign first_x      = first_x_q;
	assign first_y      = first_y_q;
	assign second_x     = second_x_q;
	assign second_y     = second_y_q;

endmodule
`default_nettype wire

// ----- design/touch_bitmap_finger_locator.sv -----
// Top level of the touchpad bitmap finger locator.
`default_nettype none
`include "touch_bitmap_finger_locator_macros.svh"
// Takes one word of X and Y contact bitmaps and returns one word with the
// finger count and the scaled centres of the first and second contacts.
// Each word goes through these steps from acceptance to the next acceptance:
// the accepting cycle, a scan of both bitmaps one line per cycle, a split of a
// lone run, then four coordinates each take a multiply and a pass through a
// shared two-bit-per-cycle divider, and a move of the result to the output
// register. That last step waits for as long as the previous word is still
// held at the output by out_stall, so a slow sink stretches the whole
// sequence. The finished word waits there while the next word is taken in.
// Registers: 0 x_range_max, 1 y_range_max, 2 x_line_count, 3 y_line_count;
// write them only while the block is idle.
module touch_bitmap_finger_locator (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tbfl_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [tbfl_pkg::RANGE_W-1:0]    cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [tbfl_pkg::MAP_BITS-1:0]   x_map,
	input  wire logic [tbfl_pkg::MAP_BITS-1:0]   y_map,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [tbfl_pkg::CNT_W-1:0]           finger_count,
	output logic [tbfl_pkg::COORD_W-1:0]         first_x,
	output logic [tbfl_pkg::COORD_W-1:0]         first_y,
	output logic [tbfl_pkg::COORD_W-1:0]         second_x,
	output logic [tbfl_pkg::COORD_W-1:0]         second_y
);
	import tbfl_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic one_finger, no_first, no_second;

	tbfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tbfl_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.x_map        (x_map),
		.y_map        (y_map),
		.cmd          (cmd),
		.sts          (sts),
		.finger_count (finger_count),
		.first_x      (first_x),
		.first_y      (first_y),
		.second_x     (second_x),
		.second_y     (second_y)
	);

	assign one_finger = (finger_count < CNT_W'(2));
	assign no_first   = (first_x == '0) && (first_y == '0);
	assign no_second  = (second_x == '0) && (second_y == '0);

	`TBFL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "word not taken up")
	`TBFL_ASSERT_SAME(a_no_overwrite, out_valid && out_stall, !cmd.load_out, "held word overwritten")
	`TBFL_ASSERT_SAME(a_single_no_second, out_valid && one_finger, no_second, "second on one finger")
	`TBFL_ASSERT_SAME(a_empty_zero, out_valid && finger_count == '0, no_first, "position, no fingers")

endmodule
`default_nettype wire
